// File: hdl/cgti_pkg.sv
// shared widths, types and arithmetic helpers for the cauchy-green inverse pipeline
package cgti_pkg;

    localparam int DataWidth = 32;
    localparam int FracBits  = 24;
    localparam int ProdWidth = 2 * DataWidth;
    localparam int SumWidth  = ProdWidth + 2;
    localparam int CofWidth  = ProdWidth + 1;
    localparam int DivSteps  = CofWidth;

    typedef logic signed [DataWidth-1:0] word_t;
    typedef logic signed [ProdWidth-1:0] prod_t;
    typedef logic signed [SumWidth-1:0]  sum_t;
    typedef logic signed [CofWidth-1:0]  cof_t;
    typedef logic [DataWidth-2:0]        mag_t;
    typedef logic [CofWidth-1:0]         cmag_t;

    localparam word_t MaxPos = {1'b0, {(DataWidth-1){1'b1}}};
    localparam word_t MinNeg = {1'b1, {(DataWidth-1){1'b0}}};

    typedef struct packed {
        word_t t11;
        word_t t12;
        word_t t13;
        word_t t22;
        word_t t23;
        word_t t33;
    } tensor_t;

    // round to nearest, ties away from zero, drop fraction bits, saturate
    function automatic word_t fix_round(input sum_t v);
        logic [SumWidth-1:0] mag;
        logic [SumWidth-1:0] rnd;
        logic [SumWidth-1:0] sh;
        logic                neg;
        begin
            neg = v[SumWidth-1];
            mag = neg ? SumWidth'(-v) : SumWidth'(v);
            rnd = mag + (SumWidth'(1) << (FracBits - 1));
            sh  = rnd >> FracBits;
            if (sh == '0)
                fix_round = '0;
            else if (!neg && sh > SumWidth'(MaxPos))
                fix_round = MaxPos;
            else if (neg && sh > SumWidth'(MaxPos) + SumWidth'(1))
                fix_round = MinNeg;
            else
                fix_round = neg ? word_t'(-sh) : word_t'(sh);
        end
    endfunction

endpackage

// File: hdl/cauchy_green_tensor_inverse.sv
// top level: tensor stages, cofactor stages, six dividers and result delay
//
// channel   signals                          direction  handshake
// request   start, busy, grad_*              in         start && !busy
// result    done, cg_*, inv_*                out        done, one cycle
//
// one request per cycle; busy is always low. each result passes through
// 6 tensor stages, 2 cofactor stages and 67 divider stages.
// the 65-bit restoring divider makes up most of those stages.
// reset clears only the valid bits; the receiver cannot stall.
module cauchy_green_tensor_inverse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cgti_pkg::word_t  grad_11,
    input  cgti_pkg::word_t  grad_12,
    input  cgti_pkg::word_t  grad_13,
    input  cgti_pkg::word_t  grad_22,
    input  cgti_pkg::word_t  grad_32,
    input  cgti_pkg::word_t  grad_33,
    output logic             done,
    output cgti_pkg::word_t  cg_11,
    output cgti_pkg::word_t  cg_12,
    output cgti_pkg::word_t  cg_13,
    output cgti_pkg::word_t  cg_22,
    output cgti_pkg::word_t  cg_23,
    output cgti_pkg::word_t  cg_33,
    output cgti_pkg::word_t  inv_11,
    output cgti_pkg::word_t  inv_12,
    output cgti_pkg::word_t  inv_13,
    output cgti_pkg::word_t  inv_22,
    output cgti_pkg::word_t  inv_23,
    output cgti_pkg::word_t  inv_33
);

    localparam int DLat = cgti_pkg::DivSteps + 2;

    logic              tv;
    cgti_pkg::tensor_t t;
    cgti_pkg::word_t   det;

    assign busy = 1'b0;

    cgti_tensor u_tensor (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .g11(grad_11), .g12(grad_12), .g13(grad_13),
        .g22(grad_22), .g32(grad_32), .g33(grad_33),
        .out_valid(tv), .tensor(t), .det(det)
    );

    // cofactor stages: products, then differences
    logic            cv1_reg, cv2_reg;
    cgti_pkg::prod_t pa_reg [12];
    cgti_pkg::cof_t  cof_reg [6];
    cgti_pkg::word_t det1_reg, det2_reg;
    cgti_pkg::tensor_t tc1_reg, tc2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv1_reg <= 1'b0;
            cv2_reg <= 1'b0;
        end
        else
        begin
            cv1_reg <= tv;
            cv2_reg <= cv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg[0]  <= t.t22 * t.t33;
        pa_reg[1]  <= t.t23 * t.t23;
        pa_reg[2]  <= t.t13 * t.t23;
        pa_reg[3]  <= t.t12 * t.t33;
        pa_reg[4]  <= t.t12 * t.t23;
        pa_reg[5]  <= t.t13 * t.t22;
        pa_reg[6]  <= t.t11 * t.t33;
        pa_reg[7]  <= t.t13 * t.t13;
        pa_reg[8]  <= t.t12 * t.t13;
        pa_reg[9]  <= t.t11 * t.t23;
        pa_reg[10] <= t.t11 * t.t22;
        pa_reg[11] <= t.t12 * t.t12;
        det1_reg   <= det;
        tc1_reg    <= t;
        for (int k = 0; k < 6; k++)
            cof_reg[k] <= cgti_pkg::CofWidth'(pa_reg[2*k])
                        - cgti_pkg::CofWidth'(pa_reg[2*k+1]);
        det2_reg <= det1_reg;
        tc2_reg  <= tc1_reg;
    end

    logic            dv [6];
    cgti_pkg::word_t q  [6];

    for (genvar k = 0; k < 6; k++)
    begin : g_div
        cgti_divide u_div (
            .clk(clk), .rst_n(rst_n), .in_valid(cv2_reg),
            .cof(cof_reg[k]), .det(det2_reg),
            .out_valid(dv[k]), .quo(q[k])
        );
    end

    // tensor entries wait alongside the dividers
    cgti_pkg::tensor_t td_reg [DLat];
    always_ff @(posedge clk)
    begin
        td_reg[0] <= tc2_reg;
        for (int i = 1; i < DLat; i++)
            td_reg[i] <= td_reg[i-1];
    end

    assign done   = dv[0];
    assign cg_11  = td_reg[DLat-1].t11;
    assign cg_12  = td_reg[DLat-1].t12;
    assign cg_13  = td_reg[DLat-1].t13;
    assign cg_22  = td_reg[DLat-1].t22;
    assign cg_23  = td_reg[DLat-1].t23;
    assign cg_33  = td_reg[DLat-1].t33;
    assign inv_11 = q[0];
    assign inv_12 = q[1];
    assign inv_13 = q[2];
    assign inv_22 = q[3];
    assign inv_23 = q[4];
    assign inv_33 = q[5];

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dv[0] == dv[5])
        else $error("divider lanes out of step");
    a_cof_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cv2_reg |-> $past(tv, 2))
        else $error("cofactor valid without tensor valid");
    a_cg11_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !cg_11[cgti_pkg::DataWidth-1])
        else $error("cg_11 negative");

endmodule

// File: hdl/cgti_tensor.sv
// tensor stages: products of the gradient, tensor entries and determinant
module cgti_tensor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cgti_pkg::word_t    g11,
    input  cgti_pkg::word_t    g12,
    input  cgti_pkg::word_t    g13,
    input  cgti_pkg::word_t    g22,
    input  cgti_pkg::word_t    g32,
    input  cgti_pkg::word_t    g33,
    output logic               out_valid,
    output cgti_pkg::tensor_t  tensor,
    output cgti_pkg::word_t    det
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    cgti_pkg::prod_t m11_reg, m12_reg, m13_reg, ma_reg, mb_reg, mc_reg;
    cgti_pkg::prod_t md_reg, me_reg, mf_reg, mg_reg, mp_reg;
    cgti_pkg::word_t g33_reg, g33_d2_reg;
    cgti_pkg::tensor_t t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    cgti_pkg::word_t p_reg;
    cgti_pkg::prod_t q_prod_reg, d_prod_reg;
    cgti_pkg::word_t q_reg, det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: raw products
        m11_reg <= g11 * g11;
        m12_reg <= g11 * g12;
        m13_reg <= g11 * g13;
        ma_reg  <= g12 * g12;
        mb_reg  <= g22 * g22;
        mc_reg  <= g32 * g32;
        md_reg  <= g12 * g13;
        me_reg  <= g32 * g33;
        mf_reg  <= g13 * g13;
        mg_reg  <= g33 * g33;
        mp_reg  <= g11 * g22;
        g33_reg <= g33;
        // stage 2: exact sums rounded once
        t2_reg.t11 <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(m11_reg));
        t2_reg.t12 <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(m12_reg));
        t2_reg.t13 <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(m13_reg));
        t2_reg.t22 <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(ma_reg)
            + cgti_pkg::SumWidth'(mb_reg) + cgti_pkg::SumWidth'(mc_reg));
        t2_reg.t23 <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(md_reg)
            + cgti_pkg::SumWidth'(me_reg));
        t2_reg.t33 <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(mf_reg)
            + cgti_pkg::SumWidth'(mg_reg));
        p_reg      <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(mp_reg));
        g33_d2_reg <= g33_reg;
        // determinant chain: p*g33, round, square, round
        q_prod_reg <= p_reg * g33_d2_reg;
        t3_reg     <= t2_reg;
        q_reg      <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(q_prod_reg));
        t4_reg     <= t3_reg;
        d_prod_reg <= q_reg * q_reg;
        t5_reg     <= t4_reg;
        det_reg    <= cgti_pkg::fix_round(cgti_pkg::SumWidth'(d_prod_reg));
        t6_reg     <= t5_reg;
    end

    assign out_valid = v6_reg;
    assign tensor    = t6_reg;
    assign det       = det_reg;

endmodule

// File: hdl/cgti_divide.sv
// pipelined restoring divider: one quotient bit per stage, saturating
module cgti_divide (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  cgti_pkg::cof_t   cof,
    input  cgti_pkg::word_t  det,
    output logic             out_valid,
    output cgti_pkg::word_t  quo
);

    localparam int N = cgti_pkg::DivSteps;

    logic                 v_reg   [N+1];
    cgti_pkg::cmag_t      num_reg [N+1];
    cgti_pkg::cmag_t      q_reg   [N+1];
    cgti_pkg::cmag_t      rem_reg [N+1];
    cgti_pkg::mag_t       den_reg [N+1];
    logic                 neg_reg [N+1];
    logic                 dz_reg  [N+1];
    cgti_pkg::word_t      quo_reg;
    logic                 vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
                v_reg[i] <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < N; i++)
                v_reg[i+1] <= v_reg[i];
            vo_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= cof[cgti_pkg::CofWidth-1];
        num_reg[0] <= cof[cgti_pkg::CofWidth-1] ? cgti_pkg::cmag_t'(-cof)
                                                : cgti_pkg::cmag_t'(cof);
        den_reg[0] <= det[cgti_pkg::DataWidth-2:0];
        dz_reg[0]  <= (det == '0);
        q_reg[0]   <= '0;
        rem_reg[0] <= '0;
        for (int i = 0; i < N; i++)
        begin
            logic [cgti_pkg::CofWidth:0] trial;
            trial = {rem_reg[i], num_reg[i][N-1-i]};
            if (trial >= (cgti_pkg::CofWidth+1)'(den_reg[i]))
            begin
                rem_reg[i+1] <= cgti_pkg::cmag_t'(trial
                    - (cgti_pkg::CofWidth+1)'(den_reg[i]));
                q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i+1] <= cgti_pkg::cmag_t'(trial);
                q_reg[i+1]   <= {q_reg[i][N-2:0], 1'b0};
            end
            num_reg[i+1] <= num_reg[i];
            den_reg[i+1] <= den_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            dz_reg[i+1]  <= dz_reg[i];
        end
        if (dz_reg[N])
            quo_reg <= neg_reg[N] ? cgti_pkg::MinNeg : cgti_pkg::MaxPos;
        else if (q_reg[N] == '0)
            quo_reg <= '0;
        else if (!neg_reg[N] && q_reg[N] > cgti_pkg::CofWidth'(cgti_pkg::MaxPos))
            quo_reg <= cgti_pkg::MaxPos;
        else if (neg_reg[N] && q_reg[N] > cgti_pkg::CofWidth'(cgti_pkg::MaxPos) + 1'b1)
            quo_reg <= cgti_pkg::MinNeg;
        else
            quo_reg <= neg_reg[N] ? cgti_pkg::word_t'(-q_reg[N])
                                  : cgti_pkg::word_t'(q_reg[N]);
    end

    assign out_valid = vo_reg;
    assign quo       = quo_reg;

endmodule
